// File: hw/rtl/cbp_pkg.sv
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared constants and register map of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cbp_pkg;

  localparam int NUM_REGS  = 8;
  localparam int IDX_BITS  = $clog2(NUM_REGS);
  localparam int ADDR_BITS = IDX_BITS + 2;
  localparam int DATA_BITS = 32;

  // register map, one word per register
  typedef enum logic [IDX_BITS-1:0] {
    REG_X0 = 3'd0,
    REG_Y0 = 3'd1,
    REG_X1 = 3'd2,
    REG_Y1 = 3'd3,
    REG_X2 = 3'd4,
    REG_Y2 = 3'd5,
    REG_X3 = 3'd6,
    REG_Y3 = 3'd7
  } reg_idx_t;

endpackage

`default_nettype wire

// File: hw/rtl/cbp_cfg.sv
// ----------------------------------------------------------------------------
// cbp_cfg
// APB register file holding the four control points.
// ----------------------------------------------------------------------------
`default_nettype none

module cbp_cfg
  import cbp_pkg::*;
#(
  parameter int COORD_BITS = 7
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [ADDR_BITS-1:0]                  paddr,
  input  wire logic [DATA_BITS-1:0]                  pwdata,
  output logic      [DATA_BITS-1:0]                  prdata,
  output logic                                       pready,
  output logic      [NUM_REGS-1:0][COORD_BITS-1:0]   coord
);

  logic [NUM_REGS-1:0][COORD_BITS-1:0] regs_r;
  logic [IDX_BITS-1:0]                 idx;
  logic                                wr_en;

  assign idx    = paddr[ADDR_BITS-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {{(DATA_BITS-COORD_BITS){1'b0}}, regs_r[idx]};
  assign coord  = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else if (wr_en) begin
      regs_r[idx] <= pwdata[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cubic_bezier_point.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point
// Exact fixed-point cubic Bezier evaluation in Bernstein form, floor of x/y.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in_       input      in_valid / in_ready     in_t_frac (Q0.T_BITS)
//  out_      output     out_valid / out_ready   out_pos_x, out_pos_y
//  cfg_      apb slave  cfg_psel/penable        cfg_paddr, cfg_pwdata, cfg_prdata
//
//  one request per cycle while the output is not stalled, through five register stages:
//  t^2/ts/s^2, cubic weights, weight times point, pair sums, final sum.
//  each stage holds its own valid bit and takes new data when it is empty or
//  the stage after it moves, so bubbles close up under a stalled output.
//  reset clears the valid bits and the control points (all zero).
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point
  import cbp_pkg::*;
#(
  parameter int COORD_BITS = 7,
  parameter int T_BITS     = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [T_BITS-1:0]     in_t_frac,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [COORD_BITS-1:0] out_pos_x,
  output logic      [COORD_BITS-1:0] out_pos_y,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [ADDR_BITS-1:0]  cfg_paddr,
  input  wire logic [DATA_BITS-1:0]  cfg_pwdata,
  output logic      [DATA_BITS-1:0]  cfg_prdata,
  output logic                       cfg_pready
);

  localparam int SW   = T_BITS + 1;          // s = 2^T - t
  localparam int W2   = 2 * T_BITS + 1;      // quadratic terms
  localparam int W3   = 3 * T_BITS + 1;      // cubic weights
  localparam int CW   = COORD_BITS + 2;      // point times 3
  localparam int PW   = W3 + CW;
  localparam int SUMW = 3 * T_BITS + COORD_BITS;

  logic [NUM_REGS-1:0][COORD_BITS-1:0] coord;

  cbp_cfg #(
    .COORD_BITS(COORD_BITS)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .coord  (coord)
  );

  // stage valids and flow control
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5     = !v5_r || out_ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: t^2, t*s, s^2
  logic [SW-1:0]     s_nxt;
  logic [2*SW-1:0]   tt_full, ts_full, ss_full;
  logic [T_BITS-1:0] t1_r;
  logic [SW-1:0]     s1_r;
  logic [W2-1:0]     tt1_r, ts1_r, ss1_r;

  assign s_nxt   = {1'b1, {T_BITS{1'b0}}} - {1'b0, in_t_frac};
  assign tt_full = in_t_frac * in_t_frac;
  assign ts_full = in_t_frac * s_nxt;
  assign ss_full = s_nxt * s_nxt;

  // stage 2: s^3, t s^2, t^2 s, t^3
  logic [W2+SW-1:0] w0_full, w1_full, w2_full, w3_full;
  logic [3:0][W3-1:0] w2_r;

  assign w0_full = ss1_r * s1_r;
  assign w1_full = ts1_r * s1_r;
  assign w2_full = tt1_r * s1_r;
  assign w3_full = tt1_r * t1_r;

  // stage 3: weight times point, middle points tripled
  function automatic logic [CW-1:0] ext1(input logic [COORD_BITS-1:0] p);
    ext1 = {2'b00, p};
  endfunction

  function automatic logic [CW-1:0] ext3(input logic [COORD_BITS-1:0] p);
    ext3 = {2'b00, p} + {1'b0, p, 1'b0};
  endfunction

  logic [1:0][3:0][CW-1:0]   coef;
  logic [1:0][3:0][PW-1:0]   prod_full;
  logic [1:0][3:0][SUMW-1:0] prod3_r;

  assign coef[0][0] = ext1(coord[REG_X0]);
  assign coef[0][1] = ext3(coord[REG_X1]);
  assign coef[0][2] = ext3(coord[REG_X2]);
  assign coef[0][3] = ext1(coord[REG_X3]);
  assign coef[1][0] = ext1(coord[REG_Y0]);
  assign coef[1][1] = ext3(coord[REG_Y1]);
  assign coef[1][2] = ext3(coord[REG_Y2]);
  assign coef[1][3] = ext1(coord[REG_Y3]);

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 4; k++) begin
        prod_full[a][k] = w2_r[k] * coef[a][k];
      end
    end
  end

  // stage 4: pair sums, stage 5: final sum and floor
  logic [1:0][1:0][SUMW-1:0] pair4_r;
  logic [1:0][SUMW-1:0]      sum_nxt;
  logic [COORD_BITS-1:0]     pos_x5_r, pos_y5_r;

  assign sum_nxt[0] = pair4_r[0][0] + pair4_r[0][1];
  assign sum_nxt[1] = pair4_r[1][0] + pair4_r[1][1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      t1_r  <= in_t_frac;
      s1_r  <= s_nxt;
      tt1_r <= tt_full[W2-1:0];
      ts1_r <= ts_full[W2-1:0];
      ss1_r <= ss_full[W2-1:0];
    end
    if (rdy2 && v1_r) begin
      w2_r[0] <= w0_full[W3-1:0];
      w2_r[1] <= w1_full[W3-1:0];
      w2_r[2] <= w2_full[W3-1:0];
      w2_r[3] <= w3_full[W3-1:0];
    end
    if (rdy3 && v2_r) begin
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 4; k++) begin
          prod3_r[a][k] <= prod_full[a][k][SUMW-1:0];
        end
      end
    end
    if (rdy4 && v3_r) begin
      for (int a = 0; a < 2; a++) begin
        pair4_r[a][0] <= prod3_r[a][0] + prod3_r[a][1];
        pair4_r[a][1] <= prod3_r[a][2] + prod3_r[a][3];
      end
    end
    if (rdy5 && v4_r) begin
      pos_x5_r <= sum_nxt[0][SUMW-1 -: COORD_BITS];
      pos_y5_r <= sum_nxt[1][SUMW-1 -: COORD_BITS];
    end
  end

  assign out_valid = v5_r;
  assign out_pos_x = pos_x5_r;
  assign out_pos_y = pos_y5_r;

endmodule

`default_nettype wire

// File: test/cubic_bezier_point_test.sv
// ----------------------------------------------------------------------------
// cubic_bezier_point_test
// Streams curve parameters through the evaluator under several sets of control
// points and compares each grid point with an exact 64-bit Bernstein-form
// computation. Idle and stall patterns vary per phase; the output is held off
// twice to fill the pipeline. Control points are read back after each load.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_point_test;
  import cbp_pkg::*;

  localparam int COORD_BITS     = 7;
  localparam int T_BITS         = 16;
  localparam int SUM_SHIFT      = 3 * T_BITS;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam logic [T_BITS-1:0]     T_MAX     = '1;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } grid_point_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [T_BITS-1:0]     in_t_frac   = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [COORD_BITS-1:0] out_pos_x;
  logic [COORD_BITS-1:0] out_pos_y;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [ADDR_BITS-1:0]  cfg_paddr   = '0;
  logic [DATA_BITS-1:0]  cfg_pwdata  = '0;
  logic [DATA_BITS-1:0]  cfg_prdata;
  logic                  cfg_pready;

  logic [COORD_BITS-1:0] ctrl_pt [NUM_REGS];
  grid_point_t           pending_points [$];
  grid_point_t           want;
  int                    error_count   = 0;
  int                    send_idle_pct = 0;
  int                    stall_pct     = 0;
  int                    holdoff_left  = 0;
  bit                    holdoff_req   = 1'b0;
  int                    quiet_cycles  = 0;

  cubic_bezier_point #(
    .COORD_BITS(COORD_BITS),
    .T_BITS    (T_BITS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_t_frac  (in_t_frac),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // floor of one coordinate; s = 2^T_BITS - t so the weights sum to 2^SUM_SHIFT
  function automatic logic [COORD_BITS-1:0] bezier_floor(
    input logic [COORD_BITS-1:0] p0, p1, p2, p3,
    input logic [T_BITS-1:0] t
  );
    logic [63:0] tt, ss, acc;
    tt  = 64'(t);
    ss  = (64'd1 << T_BITS) - tt;
    acc = 64'(p0) * ss * ss * ss
        + 64'd3 * 64'(p1) * tt * ss * ss
        + 64'd3 * 64'(p2) * tt * tt * ss
        + 64'(p3) * tt * tt * tt;
    return acc[SUM_SHIFT +: COORD_BITS];
  endfunction

  function automatic grid_point_t curve_point(input logic [T_BITS-1:0] t);
    grid_point_t pt;
    pt.x = bezier_floor(ctrl_pt[REG_X0], ctrl_pt[REG_X1], ctrl_pt[REG_X2],
                        ctrl_pt[REG_X3], t);
    pt.y = bezier_floor(ctrl_pt[REG_Y0], ctrl_pt[REG_Y1], ctrl_pt[REG_Y2],
                        ctrl_pt[REG_Y3], t);
    return pt;
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(3))
      0: return '0;
      1: return COORD_MAX;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [T_BITS-1:0] pick_t();
    case ($urandom_range(9))
      0: return T_BITS'($urandom_range(15));
      1: return T_MAX - T_BITS'($urandom_range(15));
      default: return T_BITS'($urandom);
    endcase
  endfunction

  // receiver: random stalls, or a long hold-off counted here
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result check first, then queue the prediction for a new request
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_points.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result x=%0d y=%0d", $time, out_pos_x, out_pos_y);
        end else begin
          want = pending_points.pop_front();
          if (out_pos_x !== want.x) begin
            error_count++;
            $display("%0t: pos_x expected %0d, got %0d", $time, want.x, out_pos_x);
          end
          if (out_pos_y !== want.y) begin
            error_count++;
            $display("%0t: pos_y expected %0d, got %0d", $time, want.y, out_pos_y);
          end
        end
      end
      if (in_valid && in_ready) pending_points.push_back(curve_point(in_t_frac));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles = 0;
    end else if (rst_n) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d results outstanding", $time, pending_points.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // one apb transfer, called and returning at a falling edge
  task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [DATA_BITS-1:0] data);
    logic [DATA_BITS-1:0] want_rd;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      ctrl_pt[idx] = data[COORD_BITS-1:0];
    end else begin
      want_rd = DATA_BITS'(ctrl_pt[idx]);
      if (cfg_prdata !== want_rd) begin
        error_count++;
        $display("%0t: readback of %s expected %0h, got %0h", $time, idx.name(), want_rd,
                 cfg_prdata);
      end
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // upper data bits carry junk, which the block must drop
  task automatic write_coord(input reg_idx_t idx, input logic [COORD_BITS-1:0] v);
    logic [DATA_BITS-1:0] data;
    data = $urandom;
    data[COORD_BITS-1:0] = v;
    apb_xfer(1'b1, idx, data);
  endtask

  task automatic readback_all();
    for (int i = 0; i < NUM_REGS; i++) apb_xfer(1'b0, reg_idx_t'(i), '0);
  endtask

  task automatic load_curve(input logic [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2, x3, y3);
    write_coord(REG_X0, x0);
    write_coord(REG_Y0, y0);
    write_coord(REG_X1, x1);
    write_coord(REG_Y1, y1);
    write_coord(REG_X2, x2);
    write_coord(REG_Y2, y2);
    write_coord(REG_X3, x3);
    write_coord(REG_Y3, y3);
    readback_all();
  endtask

  task automatic send_t(input logic [T_BITS-1:0] t);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid  <= 1'b0;
      in_t_frac <= T_BITS'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_t_frac <= t;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_points_done();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
  endtask

  task automatic test_reset_state();
    readback_all();
    send_t('0);
    send_t(T_MAX);
    send_t(T_BITS'(1) << (T_BITS - 1));
    wait_points_done();
  endtask

  task automatic test_directed();
    logic [T_BITS-1:0] t_list [8];
    t_list = '{'0, 16'd1, 16'h5555, 16'h8000, 16'hAAAA, 16'hFFFE, T_MAX, 16'h0100};
    // all points at the top corner: weights sum to one, so exactly max
    load_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
               COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_t('0);
    send_t(T_MAX);
    send_t(16'h8000);
    wait_points_done();
    // zigzag between opposite corners
    load_curve(COORD_MAX, '0, '0, COORD_MAX, COORD_MAX, '0, '0, COORD_MAX);
    foreach (t_list[i]) send_t(t_list[i]);
    wait_points_done();
    // all-ones data word, only the low bits are kept
    apb_xfer(1'b1, REG_X3, '1);
    apb_xfer(1'b1, REG_Y0, '1);
    readback_all();
    foreach (t_list[i]) send_t(t_list[i]);
    wait_points_done();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall, input int n_curves,
                                   input int n_items);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int c = 0; c < n_curves; c++) begin
      load_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord(), pick_coord(), pick_coord());
      for (int i = 0; i < n_items; i++) send_t(pick_t());
      wait_points_done();
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    load_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord(), pick_coord());
    for (int round = 0; round < 2; round++) begin
      holdoff_req = 1'b1;
      for (int i = 0; i < 40; i++) send_t(pick_t());
      // sender pauses until the pipeline has emptied
      wait_points_done();
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) ctrl_pt[i] = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_directed();
    test_random_phase(0, 0, 4, 105);
    test_random_phase(65, 0, 4, 105);
    test_random_phase(0, 65, 4, 105);
    test_random_phase(16, 16, 4, 105);
    test_backpressure();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_points.size() != 0) begin
      error_count++;
      $display("%0t: %0d results never arrived", $time, pending_points.size());
    end
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
